@@ rtl/core/spc_pkg.sv @@
// spc_pkg: shared types, constants and helper functions for the shape pair contact block
// used by every module under rtl/core; has no dependencies of its own
package spc_pkg;

  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;
  localparam int XW               = COORD_BITS + 4;       // working width for sums
  localparam int QW               = NORMAL_FRAC_BITS + 1; // quotient bits, one per divide cell
  localparam int RW               = COORD_BITS + 3;       // root remainder width
  localparam int DW               = 2 * COORD_BITS;       // squared distance width

  // word layout on the stream ports, first field in the lowest bits
  localparam int OFF_A_R     = 4 * COORD_BITS;
  localparam int OFF_B       = OFF_A_R + COORD_BITS - 1;
  localparam int OFF_B_R     = OFF_B + 4 * COORD_BITS;
  localparam int IN_BITS     = OFF_B_R + COORD_BITS - 1;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OFF_DEPTH   = 2 * COORD_BITS;
  localparam int OFF_NX      = OFF_DEPTH + COORD_BITS - 1;
  localparam int OFF_NY      = OFF_NX + NORMAL_BITS;
  localparam int OUT_BITS    = OFF_NY + NORMAL_BITS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    MODE_BOX_BOX       = 2'd0,
    MODE_BOX_CIRCLE    = 2'd1,
    MODE_CIRCLE_CIRCLE = 2'd2,
    MODE_NONE          = 2'd3
  } mode_t;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic        [COORD_BITS-2:0]  depth_t;
  typedef logic        [COORD_BITS-1:0]  umag_t;
  typedef logic signed [XW-1:0]          wide_t;
  typedef logic signed [NORMAL_BITS-1:0] norm_t;

  localparam norm_t N_ONE  = norm_t'(2 ** NORMAL_FRAC_BITS);
  localparam norm_t N_NEG  = -N_ONE;
  localparam wide_t C_MAX  = wide_t'(2 ** (COORD_BITS - 1) - 1);
  localparam wide_t C_MIN  = -C_MAX - wide_t'(1);

  typedef struct packed {
    mode_t  mode;
    coord_t a_x0;
    coord_t a_y0;
    coord_t a_x1;
    coord_t a_y1;
    depth_t a_radius;
    coord_t b_x0;
    coord_t b_y0;
    coord_t b_x1;
    coord_t b_y1;
    depth_t b_radius;
  } pair_t;

  // result fields plus what the root and divide cells still need
  typedef struct packed {
    logic   hit;
    logic   norm;
    coord_t px;
    coord_t py;
    depth_t depth;
    norm_t  nx;
    norm_t  ny;
    umag_t  r;
    umag_t  mx;
    umag_t  my;
    logic   sgx;
    logic   sgy;
  } ctx_t;

  typedef struct packed {
    logic [DW-1:0] rad;
    logic [RW-1:0] rem;
    umag_t         root;
  } sq_t;

  typedef struct packed {
    umag_t         rem;
    logic [QW-1:0] bits;
  } lane_t;

  typedef struct packed {
    lane_t lx;
    lane_t ly;
    umag_t len;
  } dv_t;

  // halving, rounded to nearest with halves upward
  function automatic wide_t half_w(wide_t v);
    return (v + wide_t'(1)) >>> 1;
  endfunction

  function automatic wide_t abs_w(wide_t v);
    return v < 0 ? -v : v;
  endfunction

  function automatic coord_t sat_c(wide_t v);
    coord_t res;
    if (v > C_MAX) res = coord_t'(C_MAX);
    else if (v < C_MIN) res = coord_t'(C_MIN);
    else res = v[COORD_BITS-1:0];
    return res;
  endfunction

  function automatic depth_t sat_d(wide_t v);
    depth_t res;
    if (v < 0) res = '0;
    else if (v > C_MAX) res = depth_t'(C_MAX);
    else res = v[COORD_BITS-2:0];
    return res;
  endfunction

endpackage

@@ rtl/core/shape_pair_contact_top.sv @@
// shape_pair_contact_top: contact test for one pair of 2d shapes per word
// depends on spc_pkg, spc_setup, spc_root_cell, spc_div_cell, spc_finish
//
//   channel  | direction | tdata                                     | tuser
//   s_       | in        | a_x0..a_y1, a_radius, b_x0..b_y1, b_radius | mode
//   m_       | out       | point_x, point_y, depth, normal_x, normal_y | hit
//
// the pipeline is two setup stages, one root cell per result bit,
// one divide cell per quotient bit, then the output register.
// one word enters per cycle when nothing stalls.
// a stall on m_ backs up only as far as the pipeline has no bubble to absorb it.
// rst is synchronous and empties every stage.
module shape_pair_contact_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // a_x0, a_y0, a_x1, a_y1, a_radius, b_x0, b_y0, b_x1, b_y1, b_radius, pad
  input  logic [spc_pkg::IN_TDATA_W-1:0]      s_tdata,
  // mode
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // point_x, point_y, depth, normal_x, normal_y, pad
  output logic [spc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // hit
  output logic                                m_tuser
);
  import spc_pkg::*;

  localparam int W = COORD_BITS;

  pair_t pair;

  always_comb begin
    pair.mode     = mode_t'(s_tuser);
    pair.a_x0     = s_tdata[0*W +: W];
    pair.a_y0     = s_tdata[1*W +: W];
    pair.a_x1     = s_tdata[2*W +: W];
    pair.a_y1     = s_tdata[3*W +: W];
    pair.a_radius = s_tdata[OFF_A_R +: W-1];
    pair.b_x0     = s_tdata[OFF_B + 0*W +: W];
    pair.b_y0     = s_tdata[OFF_B + 1*W +: W];
    pair.b_x1     = s_tdata[OFF_B + 2*W +: W];
    pair.b_y1     = s_tdata[OFF_B + 3*W +: W];
    pair.b_radius = s_tdata[OFF_B_R +: W-1];
  end

  logic v_s [0:W];
  logic r_s [0:W];
  ctx_t c_s [0:W];
  sq_t  q_s [0:W];

  logic v_d [0:QW];
  logic r_d [0:QW];
  ctx_t c_d [0:QW];
  dv_t  d_d [0:QW];

  spc_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pair   (pair),
    .out_valid (v_s[0]),
    .out_ready (r_s[0]),
    .out_ctx   (c_s[0]),
    .out_sq    (q_s[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_root
    spc_root_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v_s[i]),
      .in_ready  (r_s[i]),
      .in_ctx    (c_s[i]),
      .in_sq     (q_s[i]),
      .out_valid (v_s[i+1]),
      .out_ready (r_s[i+1]),
      .out_ctx   (c_s[i+1]),
      .out_sq    (q_s[i+1])
    );
  end

  // divide seed: |c| scaled to the normal's fraction plus half the length for rounding
  logic [W+QW-1:0] nsx, nsy;

  always_comb begin
    nsx = {q_s[W].root[0] & 1'b0, c_s[W].mx, {NORMAL_FRAC_BITS{1'b0}}}
        + (W+QW)'(q_s[W].root >> 1);
    nsy = {1'b0, c_s[W].my, {NORMAL_FRAC_BITS{1'b0}}}
        + (W+QW)'(q_s[W].root >> 1);
    d_d[0].len     = q_s[W].root;
    d_d[0].lx.rem  = nsx[W+QW-1:QW];
    d_d[0].lx.bits = nsx[QW-1:0];
    d_d[0].ly.rem  = nsy[W+QW-1:QW];
    d_d[0].ly.bits = nsy[QW-1:0];
  end

  assign v_d[0] = v_s[W];
  assign c_d[0] = c_s[W];
  assign r_s[W] = r_d[0];

  for (genvar j = 0; j < QW; j++) begin : g_div
    spc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v_d[j]),
      .in_ready  (r_d[j]),
      .in_ctx    (c_d[j]),
      .in_dv     (d_d[j]),
      .out_valid (v_d[j+1]),
      .out_ready (r_d[j+1]),
      .out_ctx   (c_d[j+1]),
      .out_dv    (d_d[j+1])
    );
  end

  spc_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_d[QW]),
    .in_ready (r_d[QW]),
    .in_ctx   (c_d[QW]),
    .in_dv    (d_d[QW]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ rtl/core/spc_setup.sv @@
// spc_setup: two front stages, per-mode geometry then squared distance and hit test
// depends on spc_pkg
module spc_setup (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  spc_pkg::pair_t in_pair,
  output logic           out_valid,
  input  logic           out_ready,
  output spc_pkg::ctx_t  out_ctx,
  output spc_pkg::sq_t   out_sq
);
  import spc_pkg::*;

  typedef struct packed {
    mode_t  mode;
    logic   dhit;
    coord_t dpx;
    coord_t dpy;
    depth_t ddep;
    norm_t  dnx;
    norm_t  dny;
    coord_t mpx;
    coord_t mpy;
    umag_t  r;
    umag_t  mx;
    umag_t  my;
    logic   near;
    logic   sgx;
    logic   sgy;
  } s1_t;

  s1_t  s1, s1_next;
  logic s1_valid, s1_ready, s2_ready;
  ctx_t ctx_next;
  sq_t  sq_next;

  wide_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  wide_t sax, say, eax, eay, ebx, eby, dx, dy, ox, oy;
  wide_t lx, ly, abx, aby, m2x, m2y, e2x, e2y, ddx, ddy;
  wide_t cdx, cdy, vx, vy, ux, uy, rw, midx, midy;
  umag_t rsum;

  always_comb begin
    ax0 = wide_t'(in_pair.a_x0);
    ay0 = wide_t'(in_pair.a_y0);
    ax1 = wide_t'(in_pair.a_x1);
    ay1 = wide_t'(in_pair.a_y1);
    bx0 = wide_t'(in_pair.b_x0);
    by0 = wide_t'(in_pair.b_y0);
    bx1 = wide_t'(in_pair.b_x1);
    by1 = wide_t'(in_pair.b_y1);
    // box-box in doubled units
    sax = ax0 + ax1;
    say = ay0 + ay1;
    eax = abs_w(ax1 - ax0);
    eay = abs_w(ay1 - ay0);
    ebx = abs_w(bx1 - bx0);
    eby = abs_w(by1 - by0);
    dx  = (bx0 + bx1) - sax;
    dy  = (by0 + by1) - say;
    ox  = eax + ebx - abs_w(dx);
    oy  = eay + eby - abs_w(dy);
    // box-circle: clamp the centre onto the box
    lx  = (bx0 < ax1) ? bx0 : ax1;
    lx  = (ax0 > lx) ? ax0 : lx;
    ly  = (by0 < ay1) ? by0 : ay1;
    ly  = (ay0 > ly) ? ay0 : ly;
    abx = lx - bx0;
    aby = ly - by0;
    m2x = sax;
    m2y = say;
    e2x = ax1 - ax0;
    e2y = ay1 - ay0;
    ddx = (bx0 <<< 1) - m2x;
    ddy = (by0 <<< 1) - m2y;
    // circle-circle
    cdx  = bx0 - ax0;
    cdy  = by0 - ay0;
    rsum = umag_t'(in_pair.a_radius) + umag_t'(in_pair.b_radius);
    midx = half_w(ax0 + bx0);
    midy = half_w(ay0 + by0);

    if (in_pair.mode == MODE_BOX_CIRCLE) begin
      vx = abx;
      vy = aby;
      rw = wide_t'(in_pair.b_radius);
    end else begin
      vx = cdx;
      vy = cdy;
      rw = wide_t'(rsum);
    end
    ux = abs_w(vx);
    uy = abs_w(vy);

    s1_next      = '0;
    s1_next.mode = in_pair.mode;
    s1_next.r    = rw[COORD_BITS-1:0];
    s1_next.mx   = ux[COORD_BITS-1:0];
    s1_next.my   = uy[COORD_BITS-1:0];
    s1_next.near = (ux < rw) && (uy < rw);
    s1_next.sgx  = vx[XW-1];
    s1_next.sgy  = vy[XW-1];
    case (in_pair.mode)
      MODE_BOX_BOX: begin
        s1_next.dhit = !ox[XW-1] && !oy[XW-1];
        if (ox < oy) begin
          s1_next.dpx  = sat_c(half_w(dx[XW-1] ? sax - eax : sax + eax));
          s1_next.dpy  = sat_c(half_w(say));
          s1_next.ddep = sat_d(half_w(ox));
          s1_next.dnx  = dx[XW-1] ? N_NEG : N_ONE;
        end else begin
          s1_next.dpx  = sat_c(half_w(sax));
          s1_next.dpy  = sat_c(half_w(dy[XW-1] ? say - eay : say + eay));
          s1_next.ddep = sat_d(half_w(oy));
          s1_next.dny  = dy[XW-1] ? N_NEG : N_ONE;
        end
      end
      MODE_BOX_CIRCLE: begin
        s1_next.mpx = sat_c(lx);
        s1_next.mpy = sat_c(ly);
        // deep case: push out along the dominant axis
        if (abs_w(ddx) > abs_w(ddy)) begin
          s1_next.dpx  = sat_c(half_w(ddx[XW-1] ? m2x - e2x : m2x + e2x));
          s1_next.dpy  = in_pair.b_y0;
          s1_next.ddep = sat_d(half_w(e2x - abs_w(ddx)));
          s1_next.dnx  = ddx[XW-1] ? N_NEG : N_ONE;
        end else begin
          s1_next.dpx  = in_pair.b_x0;
          s1_next.dpy  = sat_c(half_w(ddy[XW-1] ? m2y - e2y : m2y + e2y));
          s1_next.ddep = sat_d(half_w(e2y - abs_w(ddy)));
          s1_next.dny  = ddy[XW-1] ? N_NEG : N_ONE;
        end
      end
      MODE_CIRCLE_CIRCLE: begin
        s1_next.mpx  = sat_c(midx);
        s1_next.mpy  = sat_c(midy);
        s1_next.dpx  = sat_c(midx);
        s1_next.dpy  = sat_c(midy);
        s1_next.ddep = sat_d(wide_t'(rsum));
        s1_next.dny  = N_ONE;
      end
      default: ;
    endcase
  end

  logic [DW-1:0] xx, yy, rr;
  logic [DW:0]   sum;
  logic          round, h2;

  always_comb begin
    xx    = DW'(s1.mx) * DW'(s1.mx);
    yy    = DW'(s1.my) * DW'(s1.my);
    rr    = DW'(s1.r) * DW'(s1.r);
    sum   = {1'b0, xx} + {1'b0, yy};
    round = (s1.mode == MODE_BOX_CIRCLE) || (s1.mode == MODE_CIRCLE_CIRCLE);
    h2    = round && s1.near && (sum < {1'b0, rr});

    ctx_next      = '0;
    ctx_next.hit  = (s1.mode == MODE_BOX_BOX) ? s1.dhit : h2;
    ctx_next.norm = h2 && (sum != '0);
    ctx_next.r    = s1.r;
    ctx_next.mx   = s1.mx;
    ctx_next.my   = s1.my;
    ctx_next.sgx  = s1.sgx;
    ctx_next.sgy  = s1.sgy;
    if (ctx_next.norm) begin
      ctx_next.px = s1.mpx;
      ctx_next.py = s1.mpy;
    end else if (ctx_next.hit) begin
      ctx_next.px    = s1.dpx;
      ctx_next.py    = s1.dpy;
      ctx_next.depth = s1.ddep;
      ctx_next.nx    = s1.dnx;
      ctx_next.ny    = s1.dny;
    end
    sq_next      = '0;
    sq_next.rad  = sum[DW-1:0];
  end

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1 <= s1_next;
    if (s2_ready && s1_valid) begin
      out_ctx <= ctx_next;
      out_sq  <= sq_next;
    end
  end

endmodule

@@ rtl/core/spc_root_cell.sv @@
// spc_root_cell: one digit of the integer square root, two radicand bits per cell
// depends on spc_pkg
module spc_root_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spc_pkg::ctx_t in_ctx,
  input  spc_pkg::sq_t  in_sq,
  output logic          out_valid,
  input  logic          out_ready,
  output spc_pkg::ctx_t out_ctx,
  output spc_pkg::sq_t  out_sq
);
  import spc_pkg::*;

  sq_t           sq_next;
  logic [RW-1:0] rem_sh, trial;

  always_comb begin
    rem_sh       = {in_sq.rem[RW-3:0], in_sq.rad[DW-1:DW-2]};
    trial        = RW'({in_sq.root, 2'b01});
    sq_next.rad  = in_sq.rad << 2;
    if (rem_sh >= trial) begin
      sq_next.rem  = rem_sh - trial;
      sq_next.root = {in_sq.root[COORD_BITS-2:0], 1'b1};
    end else begin
      sq_next.rem  = rem_sh;
      sq_next.root = {in_sq.root[COORD_BITS-2:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ctx <= in_ctx;
      out_sq  <= sq_next;
    end
  end

endmodule

@@ rtl/core/spc_div_cell.sv @@
// spc_div_cell: one quotient bit of both normal components, restoring division by length
// depends on spc_pkg
module spc_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spc_pkg::ctx_t in_ctx,
  input  spc_pkg::dv_t  in_dv,
  output logic          out_valid,
  input  logic          out_ready,
  output spc_pkg::ctx_t out_ctx,
  output spc_pkg::dv_t  out_dv
);
  import spc_pkg::*;

  dv_t dv_next;

  function automatic lane_t step(lane_t l, umag_t len);
    logic [COORD_BITS:0] r2;
    logic [COORD_BITS:0] dif;
    lane_t               res;
    r2  = {l.rem, l.bits[QW-1]};
    dif = r2 - {1'b0, len};
    if (!dif[COORD_BITS] || r2 >= {1'b0, len}) begin
      res.rem  = dif[COORD_BITS-1:0];
      res.bits = {l.bits[QW-2:0], 1'b1};
    end else begin
      res.rem  = r2[COORD_BITS-1:0];
      res.bits = {l.bits[QW-2:0], 1'b0};
    end
    if (r2 < {1'b0, len}) begin
      res.rem  = r2[COORD_BITS-1:0];
      res.bits = {l.bits[QW-2:0], 1'b0};
    end
    return res;
  endfunction

  always_comb begin
    dv_next.lx  = step(in_dv.lx, in_dv.len);
    dv_next.ly  = step(in_dv.ly, in_dv.len);
    dv_next.len = in_dv.len;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ctx <= in_ctx;
      out_dv  <= dv_next;
    end
  end

endmodule

@@ rtl/core/spc_finish.sv @@
// spc_finish: applies depth and signed normal from root and quotients, holds the output word
// depends on spc_pkg
module spc_finish (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  spc_pkg::ctx_t                     in_ctx,
  input  spc_pkg::dv_t                      in_dv,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [spc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tuser
);
  import spc_pkg::*;

  depth_t dep;
  norm_t  nx, ny, qx, qy;

  always_comb begin
    qx  = norm_t'(in_dv.lx.bits);
    qy  = norm_t'(in_dv.ly.bits);
    dep = in_ctx.depth;
    nx  = in_ctx.nx;
    ny  = in_ctx.ny;
    if (in_ctx.norm) begin
      dep = sat_d(wide_t'(in_ctx.r) - wide_t'(in_dv.len));
      nx  = in_ctx.sgx ? -qx : qx;
      ny  = in_ctx.sgy ? -qy : qy;
    end
  end

  assign in_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (in_ready) m_tvalid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_tuser <= in_ctx.hit;
      m_tdata <= OUT_TDATA_W'({ny, nx, dep, in_ctx.py, in_ctx.px});
    end
  end

endmodule
